// ===== hw/rtl/ray_scene_closest_hit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the closest-hit engine
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_SCENE_CLOSEST_HIT_ASSERT_SVH
`define RAY_SCENE_CLOSEST_HIT_ASSERT_SVH

// A property that must hold at every clock edge.
`define RSCH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define RSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rsch_pkg.sv =====
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared widths, codes and fixed-point helpers of the closest-hit engine.
// ----------------------------------------------------------------------------
package rsch_pkg;

	localparam int CFG_W           = 7;
	localparam int VAL_W           = 32;
	localparam int NVAL            = 6;
	localparam int SLOT_W          = 6;
	localparam int KIND_W          = 2;
	localparam int DIST_W          = 31;
	localparam int S_DATA_W        = 200;
	localparam int OUT_USED_W      = 133;
	localparam int M_DATA_W        = 136;
	localparam int MAX_OBJECTS_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 2'd0,
		KIND_SPHERE = 2'd1,
		KIND_PLANE  = 2'd2,
		KIND_BOX    = 2'd3
	} kind_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_RAY  = 1'b1
	} req_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Clamp a non-negative distance to the 31-bit result range.
	function automatic logic [DIST_W-1:0] clamp_dist(input logic [63:0] v);
		logic [DIST_W-1:0] r;
		if (v > 64'h7FFF_FFFF) begin
			r = 31'h7FFF_FFFF;
		end else begin
			r = v[DIST_W-1:0];
		end
		return r;
	endfunction

	// Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

endpackage

// ===== hw/rtl/ray_scene_closest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_scene_closest_hit
// Closest-hit engine over a table of spheres, planes and boxes in fixed point.
//
// Items enter on the s_ channel. A load item (s_tuser low) writes one table
// slot and returns an all-zero result. A ray item (s_tuser high) tests slots
// 0 to min(object_count, MAX_OBJECTS)-1 and returns the nearest hit, its slot
// and its point. One result item leaves on the m_ channel for every item.
// The user must write object_count through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. Only one item is in
// flight: s_tready is high only when the engine is idle and the previous
// result has been taken, and a result waiting on m_tready holds the block. A
// load result is offered on the cycle after the load is accepted. A ray
// result is offered once every tested slot has been checked and, when
// something is hit, its hit point has been computed. Slot tests are paced by
// the single multiplier and the single bit-per-cycle divide and square root
// unit that all tests share.
// Reset empties the table through per-slot valid bits, clears object_count
// and drops any item in flight.
// ----------------------------------------------------------------------------
`include "ray_scene_closest_hit_assert.svh"

module ray_scene_closest_hit
	import rsch_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,   // object_count
	input  logic                s_tvalid,
	output logic                s_tready,
	// slot, prim_kind, val_0, val_1, val_2, val_3, val_4, val_5
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,     // req_type
	output logic                m_tvalid,
	input  logic                m_tready,
	// hit_index, hit_distance, hit_x, hit_y, hit_z, zero padding
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser      // is_hit
);

	localparam int IW        = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CNTW      = ($clog2(MAX_OBJECTS + 1) > CFG_W) ?
	                           $clog2(MAX_OBJECTS + 1) : CFG_W;
	localparam int DVW       = 33 + FRAC_BITS;
	localparam int NW        = DVW;
	localparam int SQN       = (32 + FRAC_BITS + 1) / 2;
	localparam int SQ_SH     = NW - 2 * SQN;
	localparam int TW        = DVW + 1;
	localparam int ITW       = $clog2(DVW + 1);
	localparam int ROWW      = KIND_W + NVAL * VAL_W;
	localparam int PLANE_EPS = (1 << FRAC_BITS) / 1000000;

	localparam logic signed [TW-1:0] TMAX_INF = {1'b0, {(TW-1){1'b1}}};

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_READ  = 10'b00_0000_0010,
		S_LOAD  = 10'b00_0000_0100,
		S_DOT   = 10'b00_0000_1000,
		S_ITER  = 10'b00_0001_0000,
		S_POST  = 10'b00_0010_0000,
		S_BOX   = 10'b00_0100_0000,
		S_CHECK = 10'b00_1000_0000,
		S_DONE  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		OP_B, OP_PP, OP_RR, OP_BB, OP_DEN, OP_NUM, OP_PX, OP_PY, OP_PZ
	} dop_t;

	state_t state_q;
	dop_t   op_q;

	// Object table and its valid bits.
	logic [ROWW-1:0]        obj_mem [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] vld_q;
	logic [ROWW-1:0]        rd_q;
	logic                   vrd_q;

	logic [CFG_W-1:0]       count_q;
	logic [CNTW-1:0]        n_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          best_q;
	logic                   found_q;
	logic [DIST_W-1:0]      best_t_q;
	logic                   cand_hit_q;
	logic [DIST_W-1:0]      cand_t_q;

	logic signed [31:0]     o_q [3];
	logic signed [31:0]     d_q [3];
	logic signed [31:0]     p_q [3];
	logic signed [31:0]     b_q;
	logic signed [31:0]     c_q;
	logic signed [31:0]     den_q;

	// Shared multiplier and accumulator.
	logic [1:0]             dj_q;
	logic signed [63:0]     prod_q;
	logic signed [63:0]     acc_q;

	// Shared divide and square root unit.
	logic                   it_sqrt_q;
	logic [NW-1:0]          num_q;
	logic [31:0]            dvs_q;
	logic [32:0]            rem_q;
	logic [DVW-1:0]         quo_q;
	logic [ITW-1:0]         it_cnt_q;
	logic                   neg_q;

	// Slab state of a box test.
	logic [1:0]             ax_q;
	logic                   hi_q;
	logic signed [TW-1:0]   t0_q;
	logic signed [TW-1:0]   tmin_q;
	logic signed [TW-1:0]   tmax_q;

	// Result register.
	logic                   out_hit_q;
	logic [SLOT_W-1:0]      out_idx_q;
	logic [DIST_W-1:0]      out_t_q;
	logic signed [31:0]     hx_q;
	logic signed [31:0]     hy_q;
	logic signed [31:0]     hz_q;

	logic                   in_acc;
	logic                   last_c;
	logic [IW-1:0]          wr_idx_c;
	logic                   wr_ok_c;
	logic signed [31:0]     w_c [NVAL];
	logic signed [31:0]     nrm_c [3];
	kind_t                  kind_c;

	// Handshake and table write decode.
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign in_acc   = s_tvalid && s_tready;
	assign wr_idx_c = IW'(s_tdata[SLOT_W-1:0]);
	assign wr_ok_c  = (32'(s_tdata[SLOT_W-1:0]) < 32'(MAX_OBJECTS));
	assign last_c   = ((CNTW'(idx_q) + CNTW'(1)) == n_q);

	assign m_tuser = out_hit_q;
	assign m_tdata = {{(M_DATA_W-OUT_USED_W){1'b0}}, hz_q, hy_q, hx_q, out_t_q, out_idx_q};

	// Slot words of the row being tested.
	always_comb begin
		for (int i = 0; i < NVAL; i++) begin
			w_c[i] = rd_q[VAL_W*i +: VAL_W];
		end
		for (int i = 0; i < 3; i++) begin
			nrm_c[i] = w_c[3 + i];
		end
		kind_c = vrd_q ? kind_t'(rd_q[ROWW-1 -: KIND_W]) : KIND_NONE;
	end

	// Operand selection for the shared multiplier.
	logic [1:0]         jx;
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [63:0] mul_c;
	logic signed [63:0] fl_c;
	logic signed [31:0] dres_c;

	always_comb begin
		jx = (dj_q == 2'd3) ? 2'd0 : dj_q;
		ma = '0;
		mb = '0;
		case (op_q)
			OP_B: begin
				ma = d_q[jx];
				mb = p_q[jx];
			end
			OP_PP: begin
				ma = p_q[jx];
				mb = p_q[jx];
			end
			OP_RR: begin
				if (dj_q == 2'd0) begin
					ma = w_c[3];
					mb = w_c[3];
				end
			end
			OP_BB: begin
				if (dj_q == 2'd0) begin
					ma = b_q;
					mb = b_q;
				end
			end
			OP_DEN: begin
				ma = nrm_c[jx];
				mb = d_q[jx];
			end
			OP_NUM: begin
				ma = p_q[jx];
				mb = nrm_c[jx];
			end
			OP_PX: begin
				if (dj_q == 2'd0) begin
					ma = 32'(best_t_q);
					mb = d_q[0];
				end
			end
			OP_PY: begin
				if (dj_q == 2'd0) begin
					ma = 32'(best_t_q);
					mb = d_q[1];
				end
			end
			OP_PZ: begin
				if (dj_q == 2'd0) begin
					ma = 32'(best_t_q);
					mb = d_q[2];
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Product, floor scaling and the saturated dot product.
	assign mul_c  = ma * mb;
	assign fl_c   = prod_q >>> FRAC_BITS;
	assign dres_c = sat32(acc_q + fl_c);

	// One step of the shared shift-subtract unit.
	logic [32:0] rem_sh;
	logic [32:0] trial;
	logic        ge_c;

	always_comb begin
		if (it_sqrt_q) begin
			rem_sh = {rem_q[30:0], num_q[NW-1 -: 2]};
			trial  = {quo_q[30:0], 2'b01};
		end else begin
			rem_sh = {rem_q[31:0], num_q[NW-1]};
			trial  = {1'b0, dvs_q};
		end
		ge_c = (rem_sh >= trial);
	end

	// Sphere distance from the near and far roots.
	logic signed [33:0] b34;
	logic signed [33:0] s34;
	logic signed [33:0] tm34;
	logic signed [33:0] tp34;
	logic signed [32:0] delta_c;

	assign b34     = b_q;
	assign s34     = 34'(quo_q[SQN-1:0]);
	assign tm34    = b34 - s34;
	assign tp34    = b34 + s34;
	assign delta_c = 33'(dres_c) - 33'(c_q);

	// Slab arithmetic of the current box axis.
	logic signed [31:0] bo;
	logic signed [31:0] bd;
	logic signed [31:0] blo;
	logic signed [31:0] bhi;
	logic signed [32:0] lo_df;
	logic signed [32:0] hi_df;
	logic [32:0]        lo_mag;
	logic [32:0]        hi_mag;
	logic signed [TW-1:0] q_ext;
	logic signed [TW-1:0] tq;
	logic signed [TW-1:0] lo_t;
	logic signed [TW-1:0] hi_t;
	logic signed [TW-1:0] nmin;
	logic signed [TW-1:0] nmax;

	always_comb begin
		bo     = (ax_q == 2'd3) ? o_q[0] : o_q[ax_q];
		bd     = (ax_q == 2'd3) ? d_q[0] : d_q[ax_q];
		blo    = (ax_q == 2'd3) ? w_c[0] : w_c[ax_q];
		bhi    = (ax_q == 2'd3) ? nrm_c[0] : nrm_c[ax_q];
		lo_df  = 33'(blo) - 33'(bo);
		hi_df  = 33'(bhi) - 33'(bo);
		lo_mag = lo_df[32] ? (~lo_df + 33'd1) : lo_df;
		hi_mag = hi_df[32] ? (~hi_df + 33'd1) : hi_df;
		q_ext  = TW'(quo_q);
		tq     = neg_q ? -q_ext : q_ext;
		lo_t   = bd[31] ? tq : t0_q;
		hi_t   = bd[31] ? t0_q : tq;
		nmin   = (lo_t > tmin_q) ? lo_t : tmin_q;
		nmax   = (hi_t < tmax_q) ? hi_t : tmax_q;
	end

	// Table storage and registered row read.
	always_ff @(posedge clk) begin
		if (in_acc && (req_t'(s_tuser) == REQ_LOAD) && wr_ok_c) begin
			obj_mem[wr_idx_c] <= {s_tdata[SLOT_W +: KIND_W], s_tdata[S_DATA_W-1:SLOT_W+KIND_W]};
		end
		rd_q <= obj_mem[idx_q];
	end

	// Valid bits and the count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			count_q <= '0;
			vrd_q   <= 1'b0;
		end else begin
			if (in_acc && (req_t'(s_tuser) == REQ_LOAD) && wr_ok_c) begin
				vld_q[wr_idx_c] <= 1'b1;
			end
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			vrd_q <= vld_q[idx_q];
		end
	end

	// Sequencer and shared datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
			idx_q   <= '0;
			op_q    <= OP_B;
			dj_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req_t'(s_tuser) == REQ_LOAD) begin
							out_hit_q <= 1'b0;
							out_idx_q <= '0;
							out_t_q   <= '0;
							hx_q      <= '0;
							hy_q      <= '0;
							hz_q      <= '0;
							state_q   <= S_OUT;
						end else begin
							o_q[0]  <= s_tdata[SLOT_W+KIND_W + 0*VAL_W +: VAL_W];
							o_q[1]  <= s_tdata[SLOT_W+KIND_W + 1*VAL_W +: VAL_W];
							o_q[2]  <= s_tdata[SLOT_W+KIND_W + 2*VAL_W +: VAL_W];
							d_q[0]  <= s_tdata[SLOT_W+KIND_W + 3*VAL_W +: VAL_W];
							d_q[1]  <= s_tdata[SLOT_W+KIND_W + 4*VAL_W +: VAL_W];
							d_q[2]  <= s_tdata[SLOT_W+KIND_W + 5*VAL_W +: VAL_W];
							idx_q   <= '0;
							found_q <= 1'b0;
							n_q     <= (CNTW'(count_q) < CNTW'(MAX_OBJECTS)) ?
							           CNTW'(count_q) : CNTW'(MAX_OBJECTS);
							state_q <= (count_q == '0) ? S_DONE : S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// Differences to the origin serve spheres and planes alike.
					for (int i = 0; i < 3; i++) begin
						p_q[i] <= sat32(64'(w_c[i]) - 64'(o_q[i]));
					end
					dj_q <= '0;
					case (kind_c)
						KIND_SPHERE: begin
							op_q    <= OP_B;
							state_q <= S_DOT;
						end
						KIND_PLANE: begin
							op_q    <= OP_DEN;
							state_q <= S_DOT;
						end
						KIND_BOX: begin
							ax_q    <= '0;
							tmin_q  <= '0;
							tmax_q  <= TMAX_INF;
							state_q <= S_BOX;
						end
						default: begin
							cand_hit_q <= 1'b0;
							state_q    <= S_CHECK;
						end
					endcase
				end
				S_DOT: begin
					// Three products in flight, then dispatch on the sum.
					if (dj_q != 2'd3) begin
						prod_q <= mul_c;
					end
					if (dj_q == 2'd1) begin
						acc_q <= fl_c;
					end else if (dj_q == 2'd2) begin
						acc_q <= acc_q + fl_c;
					end
					if (dj_q == 2'd3) begin
						dj_q <= '0;
						case (op_q)
							OP_B: begin
								b_q  <= dres_c;
								op_q <= OP_PP;
							end
							OP_PP: begin
								c_q  <= dres_c;
								op_q <= OP_RR;
							end
							OP_RR: begin
								c_q  <= sat32(64'(c_q) - 64'(dres_c));
								op_q <= OP_BB;
							end
							OP_BB: begin
								if (delta_c[32]) begin
									cand_hit_q <= 1'b0;
									state_q    <= S_CHECK;
								end else begin
									it_sqrt_q <= 1'b1;
									num_q     <= NW'(delta_c[31:0]) << (FRAC_BITS + SQ_SH);
									rem_q     <= '0;
									quo_q     <= '0;
									it_cnt_q  <= ITW'(SQN);
									state_q   <= S_ITER;
								end
							end
							OP_DEN: begin
								den_q <= dres_c;
								if (abs32(dres_c) <= 32'(PLANE_EPS)) begin
									cand_hit_q <= 1'b0;
									state_q    <= S_CHECK;
								end else begin
									op_q <= OP_NUM;
								end
							end
							OP_NUM: begin
								if (dres_c == '0) begin
									cand_hit_q <= 1'b1;
									cand_t_q   <= '0;
									state_q    <= S_CHECK;
								end else if (dres_c[31] != den_q[31]) begin
									cand_hit_q <= 1'b0;
									state_q    <= S_CHECK;
								end else begin
									it_sqrt_q <= 1'b0;
									num_q     <= NW'(abs32(dres_c)) << FRAC_BITS;
									dvs_q     <= abs32(den_q);
									rem_q     <= '0;
									quo_q     <= '0;
									it_cnt_q  <= ITW'(DVW);
									state_q   <= S_ITER;
								end
							end
							OP_PX: begin
								hx_q <= sat32(64'(o_q[0]) + 64'(dres_c));
								op_q <= OP_PY;
							end
							OP_PY: begin
								hy_q <= sat32(64'(o_q[1]) + 64'(dres_c));
								op_q <= OP_PZ;
							end
							OP_PZ: begin
								hz_q    <= sat32(64'(o_q[2]) + 64'(dres_c));
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end else begin
						dj_q <= dj_q + 2'd1;
					end
				end
				S_ITER: begin
					// One quotient or root bit a cycle.
					rem_q    <= ge_c ? (rem_sh - trial) : rem_sh;
					quo_q    <= {quo_q[DVW-2:0], ge_c};
					num_q    <= it_sqrt_q ? (num_q << 2) : (num_q << 1);
					it_cnt_q <= it_cnt_q - ITW'(1);
					if (it_cnt_q == ITW'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					case (kind_c)
						KIND_SPHERE: begin
							if (!tm34[33]) begin
								cand_hit_q <= 1'b1;
								cand_t_q   <= clamp_dist(64'(tm34));
							end else if (!tp34[33]) begin
								cand_hit_q <= 1'b1;
								cand_t_q   <= clamp_dist(64'(tp34));
							end else begin
								cand_hit_q <= 1'b0;
							end
							state_q <= S_CHECK;
						end
						KIND_PLANE: begin
							cand_hit_q <= 1'b1;
							cand_t_q   <= clamp_dist(64'(quo_q));
							state_q    <= S_CHECK;
						end
						KIND_BOX: begin
							if (!hi_q) begin
								// Entry distance done; start the exit distance.
								t0_q      <= tq;
								hi_q      <= 1'b1;
								num_q     <= NW'(hi_mag) << FRAC_BITS;
								neg_q     <= hi_df[32] ^ bd[31];
								rem_q     <= '0;
								quo_q     <= '0;
								it_cnt_q  <= ITW'(DVW);
								state_q   <= S_ITER;
							end else if (nmax < nmin) begin
								cand_hit_q <= 1'b0;
								state_q    <= S_CHECK;
							end else begin
								tmin_q <= nmin;
								tmax_q <= nmax;
								if (ax_q == 2'd2) begin
									cand_hit_q <= 1'b1;
									cand_t_q   <= clamp_dist(64'(nmin));
									state_q    <= S_CHECK;
								end else begin
									ax_q    <= ax_q + 2'd1;
									state_q <= S_BOX;
								end
							end
						end
						default: begin
							cand_hit_q <= 1'b0;
							state_q    <= S_CHECK;
						end
					endcase
				end
				S_BOX: begin
					// A zero direction component only checks the slab bounds.
					if (bd == '0) begin
						if ((bo < blo) || (bo > bhi)) begin
							cand_hit_q <= 1'b0;
							state_q    <= S_CHECK;
						end else if (ax_q == 2'd2) begin
							cand_hit_q <= 1'b1;
							cand_t_q   <= clamp_dist(64'(tmin_q));
							state_q    <= S_CHECK;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						it_sqrt_q <= 1'b0;
						hi_q      <= 1'b0;
						num_q     <= NW'(lo_mag) << FRAC_BITS;
						dvs_q     <= abs32(bd);
						neg_q     <= lo_df[32] ^ bd[31];
						rem_q     <= '0;
						quo_q     <= '0;
						it_cnt_q  <= ITW'(DVW);
						state_q   <= S_ITER;
					end
				end
				S_CHECK: begin
					// Strictly nearer hits replace the best, so ties keep the lower slot.
					if (cand_hit_q && (!found_q || (cand_t_q < best_t_q))) begin
						found_q  <= 1'b1;
						best_t_q <= cand_t_q;
						best_q   <= idx_q;
					end
					if (last_c) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (found_q) begin
						out_hit_q <= 1'b1;
						out_idx_q <= SLOT_W'(best_q);
						out_t_q   <= best_t_q;
						op_q      <= OP_PX;
						dj_q      <= '0;
						state_q   <= S_DOT;
					end else begin
						out_hit_q <= 1'b0;
						out_idx_q <= '0;
						out_t_q   <= '0;
						hx_q      <= '0;
						hy_q      <= '0;
						hz_q      <= '0;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and result.
	`RSCH_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_tready, "block ready right after an accepted item")
	`RSCH_ASSERT(a_miss_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "miss or load result not all zero")
	`RSCH_ASSERT(a_best_in_range, found_q |-> (CNTW'(best_q) < n_q), "best slot beyond the tested range")
	`RSCH_ASSERT(a_iter_count, (state_q == S_ITER) |-> (it_cnt_q != '0), "shift-subtract unit ran past its count")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the closest-hit engine. It loads spheres, planes and
// boxes into the table and casts rays at them. Each result item is checked
// against a fixed-point scene model in the bench (typed directed items: an
// all-zero result), over several table sizes and random gaps on both streams.
// ----------------------------------------------------------------------------
module tb
	import rsch_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q = 65536;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {OP_LOAD, OP_RAY, OP_CFG} op_t;
	typedef longint vec3_t [3];

	typedef struct packed {
		logic              hit;
		logic [5:0]        idx;
		logic [30:0]       dst;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} hit_t;

	typedef struct {
		op_t               op;
		logic [5:0]        slot;
		kind_t             kind;
		logic [31:0]       v [6];
		logic [6:0]        count;
		bit                typed;
		hit_t              want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	ray_scene_closest_hit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Scene copy held by the bench.
	kind_t  scene_kind [64];
	longint scene_words [64][6];
	int     scene_count;

	hit_t   pending_hits [$];
	int     errors;
	int     n_loads, n_rays, n_hits;
	bit     calm;

	// Clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Fixed-point helpers of the scene model.
	function automatic longint sat(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint qdot(input vec3_t a, input vec3_t b);
		return sat(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
	endfunction

	function automatic longint int_sqrt(input longint xin);
		longint unsigned x, r, b;
		x = xin;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Nearest hit over the tested slots.
	function automatic hit_t trace_ray(input vec3_t o, input vec3_t d);
		hit_t   r;
		vec3_t  c, e, p;
		longint t, best_t, b, cc, delta, s, den, num, t0, t1, tmp, tmin, tmax;
		bit     h, found;
		int     n;
		r = '0;
		found = 0;
		best_t = 0;
		n = scene_count < 64 ? scene_count : 64;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				c[k] = scene_words[i][k];
				e[k] = scene_words[i][k+3];
				p[k] = sat(c[k] - o[k]);
			end
			h = 0;
			t = 0;
			case (scene_kind[i])
				KIND_SPHERE: begin
					b = qdot(d, p);
					cc = sat(qdot(p, p) - sat(qmul(e[0], e[0])));
					delta = sat(qmul(b, b)) - cc;
					if (delta >= 0) begin
						s = int_sqrt(delta << 16);
						if (b - s >= 0) begin
							h = 1;
							t = b - s;
						end else if (b + s >= 0) begin
							h = 1;
							t = b + s;
						end
					end
				end
				KIND_PLANE: begin
					den = qdot(e, d);
					if (den != 0) begin
						num = qdot(p, e);
						if (num == 0) begin
							h = 1;
						end else if ((num < 0) == (den < 0)) begin
							h = 1;
							if (num < 0) begin
								num = -num;
								den = -den;
							end
							t = (num * ONE_Q) / den;
						end
					end
				end
				KIND_BOX: begin
					h = 1;
					tmin = 0;
					tmax = 64'sh7FFF_FFFF_FFFF_FFFF;
					for (int k = 0; k < 3 && h; k++) begin
						if (d[k] == 0) begin
							if (o[k] < c[k] || o[k] > e[k]) h = 0;
						end else begin
							t0 = ((c[k] - o[k]) * ONE_Q) / d[k];
							t1 = ((e[k] - o[k]) * ONE_Q) / d[k];
							if (d[k] < 0) begin
								tmp = t0;
								t0 = t1;
								t1 = tmp;
							end
							if (t0 > tmin) tmin = t0;
							if (t1 < tmax) tmax = t1;
							if (tmax < tmin) h = 0;
						end
					end
					t = tmin;
				end
				default: h = 0;
			endcase
			if (h) begin
				if (t > Q_MAX) t = Q_MAX;
				if (!found || t < best_t) begin
					found = 1;
					best_t = t;
					r.idx = 6'(i);
				end
			end
		end
		if (found) begin
			r.hit = 1'b1;
			r.dst = 31'(best_t);
			r.x = 32'(sat(o[0] + sat(qmul(best_t, d[0]))));
			r.y = 32'(sat(o[1] + sat(qmul(best_t, d[1]))));
			r.z = 32'(sat(o[2] + sat(qmul(best_t, d[2]))));
		end
		return r;
	endfunction

	// Apply one accepted item to the scene and return its result.
	function automatic hit_t apply_item(input row_t it);
		vec3_t o, d;
		if (it.op == OP_LOAD) begin
			scene_kind[it.slot] = it.kind;
			for (int k = 0; k < 6; k++) scene_words[it.slot][k] = longint'(signed'(it.v[k]));
			return '0;
		end
		for (int k = 0; k < 3; k++) begin
			o[k] = longint'(signed'(it.v[k]));
			d[k] = longint'(signed'(it.v[k+3]));
		end
		return trace_ray(o, d);
	endfunction

	// Stop offering items and wait until the block has returned every result.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input int n);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(n);
		@(posedge clk);
		cfg_we    <= 1'b0;
		scene_count = n;
	endtask

	// Offer one item, hold it until it is accepted, and record its result.
	task automatic send_item(input row_t it);
		hit_t r;
		if (it.op == OP_CFG) begin
			write_count(it.count);
			return;
		end
		if (!calm && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= (it.op == OP_RAY) ? REQ_RAY : REQ_LOAD;
		s_tdata  <= {it.v[5], it.v[4], it.v[3], it.v[2], it.v[1], it.v[0], it.kind, it.slot};
		do @(posedge clk); while (!s_tready);
		r = apply_item(it);
		if (it.typed) r = it.want;
		pending_hits.push_back(r);
		if (it.op == OP_RAY) begin
			n_rays++;
			if (r.hit) n_hits++;
		end else begin
			n_loads++;
		end
	endtask

	function automatic row_t mk(input op_t op, input int slot, input kind_t kind,
			input int a0, input int a1, input int a2, input int a3, input int a4,
			input int a5, input bit typed);
		row_t r;
		r.op = op;
		r.slot = 6'(slot);
		r.kind = kind;
		r.v[0] = a0; r.v[1] = a1; r.v[2] = a2;
		r.v[3] = a3; r.v[4] = a4; r.v[5] = a5;
		r.count = 7'(slot);
		r.typed = typed;
		r.want = '0;
		return r;
	endfunction

	// Random coordinate: mostly near the scene, sometimes any value.
	function automatic int rnd_pos();
		if ($urandom_range(99) < 8) return $urandom;
		return $urandom_range(0, 40 * 65536) - 20 * 65536;
	endfunction

	function automatic int rnd_dir();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) return 0;
		if (sel < 16) return $urandom;
		return $urandom_range(0, 2 * 65536) - 65536;
	endfunction

	function automatic row_t rnd_row(input int span);
		row_t r;
		kind_t k;
		int lo, hi;
		if ($urandom_range(99) < 40) begin
			k = kind_t'($urandom_range(3));
			r = mk(OP_LOAD, ($urandom_range(99) < 10) ? $urandom_range(63)
				: $urandom_range(span - 1), k, rnd_pos(), rnd_pos(), rnd_pos(), 0, 0, 0, 0);
			case (k)
				KIND_SPHERE: r.v[3] = ($urandom_range(99) < 8) ? $urandom
					: $urandom_range(1, 8 * 65536);
				KIND_BOX: begin
					for (int j = 0; j < 3; j++) begin
						lo = $urandom_range(0, 30 * 65536) - 15 * 65536;
						hi = lo + $urandom_range(0, 8 * 65536) - 65536;
						r.v[j] = lo;
						r.v[j+3] = ($urandom_range(99) < 5) ? $urandom : hi;
					end
				end
				default: begin
					r.v[3] = rnd_dir();
					r.v[4] = rnd_dir();
					r.v[5] = rnd_dir();
				end
			endcase
		end else begin
			r = mk(OP_RAY, $urandom_range(63), kind_t'($urandom_range(3)), rnd_pos(),
				rnd_pos(), rnd_pos(), rnd_dir(), rnd_dir(), rnd_dir(), 0);
		end
		return r;
	endfunction

	// Result checker and output stall.
	always @(posedge clk) begin
		hit_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[5:0], m_tdata[36:6], m_tdata[68:37],
					m_tdata[100:69], m_tdata[132:101]};
				if (pending_hits.size() == 0) begin
					$display("%0t: result with nothing pending, actual %h", $realtime, got);
					errors++;
				end else begin
					want = pending_hits.pop_front();
					if (got.hit !== want.hit || got.idx !== want.idx || got.dst !== want.dst
							|| got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
						$display("%0t: mismatch expected hit=%0d idx=%0d t=%h p=%h,%h,%h",
							$realtime, want.hit, want.idx, want.dst, want.x, want.y, want.z);
						$display("%0t:          actual   hit=%0d idx=%0d t=%h p=%h,%h,%h",
							$realtime, got.hit, got.idx, got.dst, got.x, got.y, got.z);
						errors++;
					end
				end
			end
		end
	end

	// Run limit.
	initial begin
		#100ms;
		$display("tb failed");
		$finish;
	end

	// Stimulus.
	initial begin
		row_t rows [$];
		int   counts [12];
		int   span, n_items, waited;
		errors = 0;
		n_loads = 0;
		n_rays = 0;
		n_hits = 0;
		calm = 0;
		scene_count = 0;
		for (int i = 0; i < 64; i++) begin
			scene_kind[i] = KIND_NONE;
			for (int k = 0; k < 6; k++) scene_words[i][k] = 0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: an empty scene, one of each kind, then edge cases.
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 0, 0, 65536, 1));
		rows.push_back(mk(OP_LOAD, 0, KIND_SPHERE, 0, 0, 10 * 65536, 2 * 65536, 0, 0, 1));
		rows.push_back(mk(OP_LOAD, 1, KIND_PLANE, 0, -5 * 65536, 0, 0, 65536, 0, 1));
		rows.push_back(mk(OP_LOAD, 2, KIND_BOX, -65536, -65536, 20 * 65536,
			65536, 65536, 22 * 65536, 1));
		rows.push_back(mk(OP_LOAD, 3, KIND_NONE, 0, 0, 0, 0, 0, 0, 1));
		rows.push_back(mk(OP_LOAD, 63, KIND_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 0, 0, 65536, 1));
		rows.push_back(mk(OP_CFG, 4, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
		// Sphere in front, plane below, far root from inside the sphere.
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 0, 0, 65536, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 0, -65536, 0, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 10 * 65536, 0, 0, 65536, 0));
		// Zero direction inside the box, and a ray parallel to the plane.
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 21 * 65536, 0, 0, 0, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 3 * 65536, 0, 65536, 0, 0, 0));
		// Field extremes on the ray.
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 1, 0));
		// Box with its minimum above its maximum.
		rows.push_back(mk(OP_LOAD, 3, KIND_BOX, 5 * 65536, 5 * 65536, 5 * 65536,
			-5 * 65536, -5 * 65536, -5 * 65536, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 65536, 65536, 65536, 0));
		// Equal distances: the lower slot wins.
		rows.push_back(mk(OP_LOAD, 3, KIND_SPHERE, 0, 0, 10 * 65536, 2 * 65536, 0, 0, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 0, 0, 0, 65536, 0));
		rows.push_back(mk(OP_RAY, 0, KIND_NONE, 0, 0, 30 * 65536, 0, 0, -65536, 0));
		foreach (rows[i]) send_item(rows[i]);

		// Random part over several table sizes, the extremes among them.
		counts = '{1, 3, 6, 0, 5, 2, 64, 6, 4, 127, 3, 6};
		for (int ph = 0; ph < 12; ph++) begin
			write_count(counts[ph]);
			calm = (ph == 4);
			span = (counts[ph] == 0) ? 8 : (counts[ph] > 64 ? 64 : counts[ph]);
			n_items = (counts[ph] > 8) ? 10 : 55;
			for (int i = 0; i < n_items; i++) begin
				if (ph == 2 && i == 20) drain();
				send_item(rnd_row(span));
			end
		end
		calm = 0;
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending_hits.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		$display("Covered %0d loads and %0d rays (%0d hits) over twelve table sizes.",
			n_loads, n_rays, n_hits);
		if (errors == 0 && pending_hits.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending_hits.size());
			$display("tb failed");
		end
		$finish;
	end

endmodule
